// ===== src/msgfrag_pkg.sv =====
// Shared types and constants for the message fragmenter.
// Holds the queued job format and the header step codes; no dependencies.
package msgfrag_pkg;

  localparam int FRAME_BYTES_DEF = 255;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int HDR_BYTES       = 8;

  localparam logic [7:0] HDR_VERSION = 8'h01;

  // Beat index within a header job; payload follows the eight header beats
  localparam logic [3:0] STEP_VERSION  = 4'd0;
  localparam logic [3:0] STEP_TOTAL_HI = 4'd1;
  localparam logic [3:0] STEP_TOTAL_LO = 4'd2;
  localparam logic [3:0] STEP_ID_HI    = 4'd3;
  localparam logic [3:0] STEP_ID_LO    = 4'd4;
  localparam logic [3:0] STEP_FLAGS_HI = 4'd5;
  localparam logic [3:0] STEP_FLAGS_LO = 4'd6;
  localparam logic [3:0] STEP_SOURCE   = 4'd7;
  localparam logic [3:0] STEP_PAYLOAD  = 4'd8;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_BYTE  = 1'b1;

  typedef struct packed {
    logic [7:0]  data;
    logic [6:0]  dest;
    logic        eof;
    logic        eom;
    logic        hdr;
    logic [15:0] total_len;
    logic [15:0] id;
    logic [15:0] flags;
  } msgfrag_job_t;

endpackage

// ===== src/msgfrag_front.sv =====
// Front end: accepts start and byte items, tracks message state, emits jobs.
// Depends on msgfrag_pkg.
module msgfrag_front import msgfrag_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         accept,
  input  logic         cmd,
  input  logic [14:0]  message_length,
  input  logic [6:0]   dest_address,
  input  logic [7:0]   payload_byte,
  output logic         job_push,
  output msgfrag_job_t job
);

  localparam int DATA_BYTES  = FRAME_BYTES - HDR_BYTES;
  localparam int RECIP_SHIFT = 16 + $clog2(DATA_BYTES);
  localparam longint unsigned RECIP_FULL =
      ((longint'(1) << RECIP_SHIFT) + longint'(DATA_BYTES) - 1) / longint'(DATA_BYTES);
  localparam logic [16:0] RECIP_MUL = RECIP_FULL[16:0];

  logic [15:0] message_id;
  logic [14:0] msg_len_reg;
  logic [15:0] total_len_reg;
  logic [14:0] bytes_sent;
  logic [7:0]  frag_fill;
  logic [6:0]  dest_reg;
  logic        active;

  logic [15:0] numer;
  logic [32:0] prod;
  logic [12:0] frags;
  logic [15:0] total_next;
  logic [14:0] remaining;
  logic        more;
  logic [14:0] bytes_next;
  logic [7:0]  fill_inc;
  logic        eom;
  logic        eof;

  // Fragment count by reciprocal multiply, exact for every 15-bit message length at the default frame size
  assign numer      = {1'b0, message_length} + 16'(DATA_BYTES - 1);
  assign prod       = 33'(numer) * 33'(RECIP_MUL);
  assign frags      = 13'(prod >> RECIP_SHIFT);
  assign total_next = {frags, 3'b000} + {1'b0, message_length};

  assign remaining  = msg_len_reg - bytes_sent;
  assign more       = remaining > 15'(DATA_BYTES);
  assign bytes_next = bytes_sent + 15'd1;
  assign fill_inc   = frag_fill + 8'd1;
  assign eom        = bytes_next == msg_len_reg;
  assign eof        = eom || (fill_inc >= 8'(DATA_BYTES));

  assign job_push = accept && (cmd == CMD_BYTE) && active;

  always_comb begin
    job.data      = payload_byte;
    job.dest      = dest_reg;
    job.eof       = eof;
    job.eom       = eom;
    job.hdr       = frag_fill == 8'd0;
    job.total_len = total_len_reg;
    job.id        = message_id;
    job.flags     = {more, bytes_sent};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      message_id    <= '0;
      msg_len_reg   <= '0;
      total_len_reg <= '0;
      bytes_sent    <= '0;
      frag_fill     <= '0;
      dest_reg      <= '0;
      active        <= 1'b0;
    end else if (accept) begin
      if (cmd == CMD_START) begin
        message_id    <= message_id + 16'd1;
        msg_len_reg   <= message_length;
        total_len_reg <= total_next;
        dest_reg      <= dest_address;
        bytes_sent    <= '0;
        frag_fill     <= '0;
        active        <= message_length != 15'd0;
      end else if (active) begin
        bytes_sent <= bytes_next;
        frag_fill  <= eof ? 8'd0 : fill_inc;
        if (eom) begin
          active <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== src/msgfrag_queue.sv =====
// Short job queue between front and back ends, register based.
// Depends on msgfrag_pkg.
module msgfrag_queue import msgfrag_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  msgfrag_job_t wr_job,
  output logic         full,
  input  logic         pop,
  output msgfrag_job_t rd_job,
  output logic         empty
);

  localparam int PTR_W = $clog2(DEPTH);

  msgfrag_job_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full   = count == (PTR_W+1)'(DEPTH);
  assign empty  = count == '0;
  assign rd_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (PTR_W+1)'(1);
        2'b01:   count <= count - (PTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/msgfrag_back.sv =====
// Back end: expands jobs into header and payload beats into an output register.
// Holds the source address register. Depends on msgfrag_pkg.
module msgfrag_back import msgfrag_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_write,
  input  logic [6:0]   cfg_data,
  input  msgfrag_job_t job,
  input  logic         job_empty,
  output logic         job_pop,
  output logic         empty,
  input  logic         pop,
  output logic [7:0]   frame_byte,
  output logic [6:0]   frame_dest,
  output logic         end_of_frame,
  output logic         end_of_message
);

  logic [6:0] source_address;
  logic [3:0] step;
  logic       out_valid;
  logic       out_free;
  logic       take;
  logic       last_beat;
  logic [7:0] beat_byte;

  assign out_free  = !out_valid || pop;
  assign take      = out_free && !job_empty;
  assign last_beat = !job.hdr || (step == STEP_PAYLOAD);
  assign job_pop   = take && last_beat;
  assign empty     = !out_valid;

  always_comb begin
    case (step)
      STEP_VERSION:  beat_byte = HDR_VERSION;
      STEP_TOTAL_HI: beat_byte = job.total_len[15:8];
      STEP_TOTAL_LO: beat_byte = job.total_len[7:0];
      STEP_ID_HI:    beat_byte = job.id[15:8];
      STEP_ID_LO:    beat_byte = job.id[7:0];
      STEP_FLAGS_HI: beat_byte = job.flags[15:8];
      STEP_FLAGS_LO: beat_byte = job.flags[7:0];
      STEP_SOURCE:   beat_byte = {1'b0, source_address};
      default:       beat_byte = job.data;
    endcase
    if (!job.hdr) begin
      beat_byte = job.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_address <= '0;
    end else if (cfg_write) begin
      source_address <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= STEP_VERSION;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        step <= last_beat ? STEP_VERSION : step + 4'd1;
      end
      if (out_free) begin
        out_valid <= !job_empty;
      end
    end
  end

  // Load the next beat whenever the output slot frees up and a job is waiting
  always_ff @(posedge clk) begin
    if (take) begin
      frame_byte     <= beat_byte;
      frame_dest     <= job.dest;
      end_of_frame   <= last_beat && job.eof;
      end_of_message <= last_beat && job.eom;
    end
  end

endmodule

// ===== src/message_fragmenter_unit.sv =====
// Message fragmenter: splits a byte stream into fragments with 8-byte headers.
// Path: with the back end idle, an input byte is written into the job queue and then loaded
// into the output register; a fragment's first byte follows its eight header beats.
// Throughput: one beat per cycle on each side when not stalled; each fragment adds eight header beats,
// which a four-entry job queue absorbs until it fills and stalls input.
// Reset clears message id, message state, source address and the job queue.
// Depends on msgfrag_pkg, msgfrag_front, msgfrag_queue, msgfrag_back.
module message_fragmenter_unit import msgfrag_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        cmd,
  input  logic [14:0] message_length,
  input  logic [6:0]  dest_address,
  input  logic [7:0]  payload_byte,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  frame_byte,
  output logic [6:0]  frame_dest,
  output logic        end_of_frame,
  output logic        end_of_message,
  input  logic        cfg_write,
  input  logic [6:0]  cfg_data
);

  msgfrag_job_t push_job;
  msgfrag_job_t head_job;
  logic         job_push;
  logic         job_pop;
  logic         job_empty;
  logic         accept;

  assign accept = push && !full;

  msgfrag_front #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .cmd            (cmd),
    .message_length (message_length),
    .dest_address   (dest_address),
    .payload_byte   (payload_byte),
    .job_push       (job_push),
    .job            (push_job)
  );

  msgfrag_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (job_push),
    .wr_job (push_job),
    .full   (full),
    .pop    (job_pop),
    .rd_job (head_job),
    .empty  (job_empty)
  );

  msgfrag_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .job            (head_job),
    .job_empty      (job_empty),
    .job_pop        (job_pop),
    .empty          (empty),
    .pop            (pop),
    .frame_byte     (frame_byte),
    .frame_dest     (frame_dest),
    .end_of_frame   (end_of_frame),
    .end_of_message (end_of_message)
  );

endmodule
